// ----- rtl/ppu_crp_pkg.sv -----
`default_nettype none

package ppu_crp_pkg;

    localparam int OAM_BYTES       = 256;
    localparam int NAMETABLE_BYTES = 2048;
    localparam int PALETTE_BYTES   = 32;

    localparam int OAM_AW = $clog2(OAM_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    typedef enum logic [1:0] {
        REQ_READ     = 2'd0,
        REQ_WRITE    = 2'd1,
        REQ_VBLANK   = 2'd2,
        REQ_PRERENDR = 2'd3
    } req_t;

    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [1:0] MIR_HORIZ    = 2'd0;
    localparam logic [1:0] MIR_VERT     = 2'd1;
    localparam logic [1:0] MIR_SCREEN_A = 2'd2;
    localparam logic [1:0] MIR_SCREEN_B = 2'd3;

    // Write side of the three on-chip memories
    typedef struct packed {
        logic              oam_we;
        logic [OAM_AW-1:0] oam_ptr;
        logic              nt_we;
        logic [NT_AW-1:0]  nt_addr;
        logic              pal_we;
        logic [PAL_AW-1:0] pal_ptr;
        logic [7:0]        wdata;
    } mem_wr_t;

    // Read side, issued when a request is taken
    typedef struct packed {
        logic              en;
        logic [OAM_AW-1:0] oam_ptr;
        logic [NT_AW-1:0]  nt_addr;
        logic [PAL_AW-1:0] pal_ptr;
    } mem_rd_t;

    function automatic logic [NT_AW-1:0] nt_index(input logic [13:0] a,
                                                  input logic [1:0]  mir);
        logic page;
        begin
            unique case (mir)
                MIR_HORIZ:    page = a[11];
                MIR_VERT:     page = a[10];
                MIR_SCREEN_A: page = 1'b0;
                MIR_SCREEN_B: page = 1'b1;
                default:      page = 1'b0;
            endcase
            return {page, a[9:0]};
        end
    endfunction

    // sprite backdrop entries fold onto the background ones
    function automatic logic [PAL_AW-1:0] pal_index(input logic [13:0] a);
        logic [PAL_AW-1:0] i;
        begin
            i = a[PAL_AW-1:0];
            if (i[4] && (i[1:0] == 2'b00))
            begin
                i[4] = 1'b0;
            end
            return i;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ppu_crp_mem.sv -----
`default_nettype none

module ppu_crp_mem
    import ppu_crp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mem_rd_t    rd,
    input  wire mem_wr_t    wr,
    output logic [7:0]      oam_rdata,
    output logic [7:0]      nt_rdata,
    output logic [7:0]      pal_rdata,
    output logic            clr_busy
);

    logic [7:0] oam_mem [OAM_BYTES];
    logic [7:0] nt_mem  [NAMETABLE_BYTES];
    logic [7:0] pal_mem [PALETTE_BYTES];

    logic [7:0] oam_rdata_reg, nt_rdata_reg, pal_rdata_reg;

    // zeroing sweep after reset; the largest memory sets its length
    logic             clr_active_reg, clr_active_next;
    logic [NT_AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic              oam_we, nt_we, pal_we;
    logic [OAM_AW-1:0] oam_waddr;
    logic [NT_AW-1:0]  nt_waddr;
    logic [PAL_AW-1:0] pal_waddr;
    logic [7:0]        wdata;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == NT_AW'(NAMETABLE_BYTES - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            oam_we    = 1'b1;
            nt_we     = 1'b1;
            pal_we    = 1'b1;
            oam_waddr = clr_cnt_reg[OAM_AW-1:0];
            nt_waddr  = clr_cnt_reg;
            pal_waddr = clr_cnt_reg[PAL_AW-1:0];
            wdata     = 8'h00;
        end
        else
        begin
            oam_we    = wr.oam_we;
            nt_we     = wr.nt_we;
            pal_we    = wr.pal_we;
            oam_waddr = wr.oam_ptr;
            nt_waddr  = wr.nt_addr;
            pal_waddr = wr.pal_ptr;
            wdata     = wr.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
        begin
            oam_mem[oam_waddr] <= wdata;
        end
        if (rd.en)
        begin
            oam_rdata_reg <= oam_mem[rd.oam_ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nt_mem[nt_waddr] <= wdata;
        end
        if (rd.en)
        begin
            nt_rdata_reg <= nt_mem[rd.nt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= wdata;
        end
        if (rd.en)
        begin
            pal_rdata_reg <= pal_mem[rd.pal_ptr];
        end
    end

    assign oam_rdata = oam_rdata_reg;
    assign nt_rdata  = nt_rdata_reg;
    assign pal_rdata = pal_rdata_reg;
    assign clr_busy  = clr_active_reg;

endmodule

`default_nettype wire

// ----- rtl/ppu_cpu_register_port.sv -----
`default_nettype none

// Channel   Handshake                   Payload
// -------   -------------------------   ------------------------------------------
// in        in_valid / in_stall         req_type reg_index write_data pattern_data
// out       out_valid / out_stall       read_data nmi_pulse pattern_* *_now
// config    cfg_we                      mirroring
//
// Each request is handled in steps: the accept edge issues the OAM, nametable and
// palette reads, the finishing edge updates the registers, writes the memories and
// loads the result register. Another request is taken only once the pending one finishes.
// After reset the memories are zeroed by a sweep; in_stall stays high meanwhile.
// A held result in the output register stalls the finishing step only.

module ppu_cpu_register_port
    import ppu_crp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  mirroring,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [2:0]  reg_index,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  pattern_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic             nmi_pulse,
    output logic             pattern_write,
    output logic [12:0]      pattern_addr,
    output logic [7:0]       pattern_wdata,
    output logic [14:0]      vram_addr_now,
    output logic [14:0]      temp_addr_now,
    output logic [2:0]       fine_x_now,
    output logic [7:0]       control_now,
    output logic [7:0]       mask_now
);

    logic [1:0]  mirroring_reg;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic        vblank_reg, vblank_next;
    logic [14:0] cur_addr_reg, cur_addr_next;
    logic [14:0] tmp_addr_reg, tmp_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  oam_ptr_reg, oam_ptr_next;
    logic [7:0]  rbuf_reg, rbuf_next;

    logic        s1_valid_reg;
    req_t        req_reg;
    logic [2:0]  reg_index_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  pdata_reg;

    logic        out_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic        nmi_reg, nmi_next;
    logic        pat_we_reg, pat_we_next;
    logic [12:0] pat_addr_reg, pat_addr_next;
    logic [7:0]  pat_wdata_reg, pat_wdata_next;

    logic        clr_busy;
    logic        in_accept;
    logic        finish;
    logic [7:0]  oam_rdata, nt_rdata, pal_rdata;
    mem_rd_t     mem_rd;
    mem_wr_t     mem_wr;

    logic [13:0] data_addr;
    logic        at_pattern, at_palette;
    logic [14:0] addr_step;

    assign in_stall  = clr_busy || s1_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign finish    = s1_valid_reg && (!out_valid_reg || !out_stall);

    assign data_addr  = cur_addr_reg[13:0];
    assign at_pattern = !data_addr[13];
    assign at_palette = (data_addr[13:8] == 6'h3F);
    assign addr_step  = ctrl_reg[2] ? 15'd32 : 15'd1;

    always_comb
    begin
        mem_rd.en      = in_accept;
        mem_rd.oam_ptr = oam_ptr_reg;
        mem_rd.nt_addr = nt_index(data_addr, mirroring_reg);
        mem_rd.pal_ptr = pal_index(data_addr);
    end

    ppu_crp_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (mem_rd),
        .wr        (mem_wr),
        .oam_rdata (oam_rdata),
        .nt_rdata  (nt_rdata),
        .pal_rdata (pal_rdata),
        .clr_busy  (clr_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirroring_reg <= MIR_HORIZ;
        end
        else if (cfg_we)
        begin
            mirroring_reg <= mirroring;
        end
    end

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (finish)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg       <= req_t'(req_type);
            reg_index_reg <= reg_index;
            wdata_reg     <= write_data;
            pdata_reg     <= pattern_data;
        end
    end

    // finishing step: state update and memory writes
    always_comb
    begin
        ctrl_next      = ctrl_reg;
        mask_next      = mask_reg;
        vblank_next    = vblank_reg;
        cur_addr_next  = cur_addr_reg;
        tmp_addr_next  = tmp_addr_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        oam_ptr_next   = oam_ptr_reg;
        rbuf_next      = rbuf_reg;
        read_data_next = 8'h00;
        nmi_next       = 1'b0;
        pat_we_next    = 1'b0;
        pat_addr_next  = 13'd0;
        pat_wdata_next = 8'h00;

        mem_wr.oam_we  = 1'b0;
        mem_wr.oam_ptr = oam_ptr_reg;
        mem_wr.nt_we   = 1'b0;
        mem_wr.nt_addr = nt_index(data_addr, mirroring_reg);
        mem_wr.pal_we  = 1'b0;
        mem_wr.pal_ptr = pal_index(data_addr);
        mem_wr.wdata   = wdata_reg;

        unique case (req_reg)
            REQ_READ:
            begin
                unique case (reg_index_reg)
                    REG_STATUS:
                    begin
                        read_data_next = {vblank_reg, 7'd0};
                        vblank_next    = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    REG_OAMDATA:
                    begin
                        read_data_next = oam_rdata;
                    end
                    REG_DATA:
                    begin
                        if (at_pattern)
                        begin
                            read_data_next = rbuf_reg;
                            rbuf_next      = pdata_reg;
                            pat_addr_next  = data_addr[12:0];
                        end
                        else if (!at_palette)
                        begin
                            read_data_next = rbuf_reg;
                            rbuf_next      = nt_rdata;
                        end
                        else
                        begin
                            // palette is direct, buffer takes the nametable byte below
                            read_data_next = pal_rdata;
                            rbuf_next      = nt_rdata;
                        end
                        cur_addr_next = cur_addr_reg + addr_step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_WRITE:
            begin
                unique case (reg_index_reg)
                    REG_CTRL:
                    begin
                        ctrl_next            = wdata_reg;
                        tmp_addr_next[11:10] = wdata_reg[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_next = wdata_reg;
                    end
                    REG_OAMADDR:
                    begin
                        oam_ptr_next = wdata_reg;
                    end
                    REG_OAMDATA:
                    begin
                        mem_wr.oam_we = finish;
                        oam_ptr_next  = oam_ptr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            fine_x_next        = wdata_reg[2:0];
                            tmp_addr_next[4:0] = wdata_reg[7:3];
                            toggle_next        = 1'b1;
                        end
                        else
                        begin
                            tmp_addr_next[14:12] = wdata_reg[2:0];
                            tmp_addr_next[9:5]   = wdata_reg[7:3];
                            toggle_next          = 1'b0;
                        end
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            tmp_addr_next[13:8] = wdata_reg[5:0];
                            tmp_addr_next[14]   = 1'b0;
                            toggle_next         = 1'b1;
                        end
                        else
                        begin
                            tmp_addr_next[7:0] = wdata_reg;
                            cur_addr_next      = {tmp_addr_reg[14:8], wdata_reg};
                            toggle_next        = 1'b0;
                        end
                    end
                    REG_DATA:
                    begin
                        if (at_pattern)
                        begin
                            pat_we_next    = 1'b1;
                            pat_addr_next  = data_addr[12:0];
                            pat_wdata_next = wdata_reg;
                        end
                        else if (!at_palette)
                        begin
                            mem_wr.nt_we = finish;
                        end
                        else
                        begin
                            mem_wr.pal_we = finish;
                        end
                        cur_addr_next = cur_addr_reg + addr_step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_VBLANK:
            begin
                vblank_next = 1'b1;
                nmi_next    = ctrl_reg[7];
            end
            REQ_PRERENDR:
            begin
                vblank_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= '0;
            mask_reg     <= '0;
            vblank_reg   <= 1'b0;
            cur_addr_reg <= '0;
            tmp_addr_reg <= '0;
            fine_x_reg   <= '0;
            toggle_reg   <= 1'b0;
            oam_ptr_reg  <= '0;
            rbuf_reg     <= '0;
        end
        else if (finish)
        begin
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            vblank_reg   <= vblank_next;
            cur_addr_reg <= cur_addr_next;
            tmp_addr_reg <= tmp_addr_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            oam_ptr_reg  <= oam_ptr_next;
            rbuf_reg     <= rbuf_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            read_data_reg <= read_data_next;
            nmi_reg       <= nmi_next;
            pat_we_reg    <= pat_we_next;
            pat_addr_reg  <= pat_addr_next;
            pat_wdata_reg <= pat_wdata_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign nmi_pulse     = nmi_reg;
    assign pattern_write = pat_we_reg;
    assign pattern_addr  = pat_addr_reg;
    assign pattern_wdata = pat_wdata_reg;
    // state only moves on finish, so it matches the held result
    assign vram_addr_now = cur_addr_reg;
    assign temp_addr_now = tmp_addr_reg;
    assign fine_x_now    = fine_x_reg;
    assign control_now   = ctrl_reg;
    assign mask_now      = mask_reg;

    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !finish |=> s1_valid_reg)
        else $error("pending request dropped without a result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid && !s1_valid_reg)
        else $error("finished request did not load the result register");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !(mem_wr.oam_we || mem_wr.nt_we || mem_wr.pal_we) && !s1_valid_reg)
        else $error("memory write request during zeroing sweep");

    a_rise_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result appeared without a pending request");

endmodule

`default_nettype wire
